FILE: design/sbtr_pkg.sv
// Shared types, constants and font ROM of the scaled bitmap text rasterizer.
`default_nettype none
package sbtr_pkg;

	localparam int MaxScale  = 4;
	localparam int CoordBits = 11;
	localparam int PenBits   = 12;
	localparam int RowBits   = 12;
	localparam int ColBits   = 13;
	localparam int IndexBits = 22;
	localparam int LenBits   = 3;
	localparam int InkBits   = 32;
	localparam int CellBits  = 4;
	localparam int GlyphBits = 15;
	localparam int AddrBits  = 5;

	localparam logic [PenBits-1:0]  PEN_MAX     = 12'd4095;
	localparam logic [7:0]          GLYPH_FIRST = 8'd32;
	localparam logic [7:0]          GLYPH_LAST  = 8'd126;
	localparam logic [CellBits-1:0] CELL_LAST   = 4'd14;
	localparam logic [1:0]          COL_LAST    = 2'd2;
	localparam logic [LenBits-1:0]  SCALE_MAX   = 3'(MaxScale);

	// register indexes on the configuration port
	localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
	localparam logic [2:0] REG_GLYPH_SCALE = 3'd2;
	localparam logic [2:0] REG_FB_WIDTH    = 3'd3;
	localparam logic [2:0] REG_FB_HEIGHT   = 3'd4;
	localparam logic [2:0] REG_INK_COLOR   = 3'd5;

	typedef struct packed {
		logic [CoordBits-1:0] origin_x;
		logic [CoordBits-1:0] origin_y;
		logic [LenBits-1:0]   glyph_scale;
		logic [CoordBits-1:0] fb_width;
		logic [CoordBits-1:0] fb_height;
		logic [InkBits-1:0]   ink_color;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic step;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic hold_valid;
		logic iter_last;
	} sts_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH
	} state_t;

	// 3x5 glyphs for codes 32..126, bit dy*3+dx is column dx of row dy
	localparam logic [15:0] GLYPH_ROM [0:94] = '{
		16'h0000,16'h2092,16'h002d,16'h5f7d,16'h279e,16'h52a5,16'h7ad6,16'h0012,
		16'h4494,16'h1491,16'h017a,16'h05d0,16'h1400,16'h01c0,16'h0400,16'h12a4,
		16'h2b6a,16'h749a,16'h752a,16'h38a3,16'h4f4a,16'h38cf,16'h3bce,16'h12a7,
		16'h3aae,16'h49ae,16'h0410,16'h1410,16'h4454,16'h0e38,16'h1511,16'h10e3,
		16'h73ee,16'h5f7a,16'h3beb,16'h624e,16'h3b6b,16'h73cf,16'h13cf,16'h6b4e,
		16'h5bed,16'h7497,16'h2b27,16'h5add,16'h7249,16'h5b7d,16'h5b6b,16'h3b6e,
		16'h12eb,16'h4f6b,16'h5aeb,16'h388e,16'h2497,16'h6b6d,16'h256d,16'h5f6d,
		16'h5aad,16'h24ad,16'h72a7,16'h6496,16'h4889,16'h3493,16'h002a,16'hf000,
		16'h0011,16'h6b98,16'h3b79,16'h7270,16'h7b74,16'h6750,16'h95d6,16'hb9ee,
		16'h5b59,16'h6410,16'hb482,16'h56e8,16'h6492,16'h5be8,16'h5b58,16'h3b70,
		16'h976a,16'hcd6a,16'h1370,16'h38f0,16'h64ba,16'h3b68,16'h2568,16'h5f68,
		16'h54a8,16'hb9ad,16'h73b8,16'h64d6,16'h2492,16'h3593,16'h03e0
	};

endpackage
`default_nettype wire

FILE: design/sbtr_ctrl.sv
// Controller state machine: sequences load, cell walk and final flush.
`default_nettype none
module sbtr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire sbtr_pkg::sts_t sts,
	output sbtr_pkg::cmd_t     cmd
);

	sbtr_pkg::state_t state_q;
	sbtr_pkg::state_t state_nx;

	// hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbtr_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			sbtr_pkg::ST_IDLE: begin
				if (in_valid) state_nx = sbtr_pkg::ST_RUN;
			end
			sbtr_pkg::ST_RUN: begin
				if (sts.out_free && sts.iter_last) state_nx = sbtr_pkg::ST_FLUSH;
			end
			sbtr_pkg::ST_FLUSH: begin
				if (!sts.hold_valid || sts.out_free) state_nx = sbtr_pkg::ST_IDLE;
			end
			default: state_nx = sbtr_pkg::ST_IDLE;
		endcase
	end

	// commands to the datapath
	always_comb begin
		in_ready  = 1'b0;
		cmd       = '0;
		unique case (state_q)
			sbtr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			sbtr_pkg::ST_RUN: begin
				cmd.step = sts.out_free;
			end
			sbtr_pkg::ST_FLUSH: begin
				cmd.flush = sts.hold_valid && sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: design/sbtr_dp.sv
// Datapath: pen, glyph cell walk, span address, hold stage and output register.
`default_nettype none
module sbtr_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire sbtr_pkg::cfg_t                  cfg,
	input  wire sbtr_pkg::cmd_t                  cmd,
	output sbtr_pkg::sts_t                       sts,
	input  wire logic [7:0]                      char_code,
	input  wire logic                            first_of_string,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [sbtr_pkg::IndexBits-1:0]       pixel_index,
	output logic [sbtr_pkg::LenBits-1:0]         span_length,
	output logic [sbtr_pkg::InkBits-1:0]         ink_value,
	output logic                                 last_span
);

	// character state
	logic [sbtr_pkg::PenBits-1:0]   pen_q;
	logic [sbtr_pkg::PenBits-1:0]   base_q;
	logic [sbtr_pkg::GlyphBits-1:0] bits_q;
	logic [sbtr_pkg::LenBits-1:0]   scale_q;
	logic [sbtr_pkg::CellBits-1:0]  cell_q;
	logic [1:0]                     dx_q;
	logic [1:0]                     r_q;
	logic [3:0]                     xoff_q;
	logic [4:0]                     yoff_q;

	// hold stage and output register
	logic                           hold_v_q;
	logic [sbtr_pkg::IndexBits-1:0] hold_idx_q;
	logic [sbtr_pkg::LenBits-1:0]   hold_len_q;
	logic                           out_v_q;
	logic [sbtr_pkg::IndexBits-1:0] out_idx_q;
	logic [sbtr_pkg::LenBits-1:0]   out_len_q;
	logic [sbtr_pkg::InkBits-1:0]   out_ink_q;
	logic                           out_last_q;

	// load-time values
	logic [sbtr_pkg::LenBits-1:0]   scale_c;
	logic [sbtr_pkg::PenBits-1:0]   base_c;
	logic [sbtr_pkg::PenBits:0]     pen_sum;
	logic [15:0]                    glyph_c;
	logic [7:0]                     rom_off;

	// per-step values
	logic [sbtr_pkg::ColBits-1:0]   col;
	logic [sbtr_pkg::RowBits-1:0]   row;
	logic                           col_in;
	logic                           row_in;
	logic                           emit;
	logic                           next_cell;
	logic [sbtr_pkg::CoordBits-1:0] room;
	logic [sbtr_pkg::LenBits-1:0]   len_c;
	logic [22:0]                    row_base;
	logic [23:0]                    idx_sum;
	logic                           out_free;

	// clamp the scale and look up the glyph
	always_comb begin
		scale_c = (cfg.glyph_scale > sbtr_pkg::SCALE_MAX) ? sbtr_pkg::SCALE_MAX
		                                                  : cfg.glyph_scale;
		base_c  = first_of_string ? {1'b0, cfg.origin_x} : pen_q;
		pen_sum = {1'b0, base_c} + {(sbtr_pkg::PenBits - 4)'(0), scale_c, 2'b00};
		rom_off = char_code - sbtr_pkg::GLYPH_FIRST;
		if (char_code > sbtr_pkg::GLYPH_FIRST && char_code <= sbtr_pkg::GLYPH_LAST) begin
			glyph_c = sbtr_pkg::GLYPH_ROM[rom_off[6:0]];
		end else begin
			glyph_c = '0;
		end
	end

	// place the current pixel row of the current cell
	always_comb begin
		col      = {1'b0, base_q} + {(sbtr_pkg::ColBits - 4)'(0), xoff_q};
		row      = {1'b0, cfg.origin_y} + {(sbtr_pkg::RowBits - 5)'(0), yoff_q}
		         + {(sbtr_pkg::RowBits - 2)'(0), r_q};
		col_in   = col < {2'b00, cfg.fb_width};
		row_in   = row < {1'b0, cfg.fb_height};
		emit     = bits_q[0] && (scale_q != '0) && col_in && row_in;
		next_cell = !emit || ({1'b0, r_q} == (scale_q - 3'd1));
		room     = cfg.fb_width - col[sbtr_pkg::CoordBits-1:0];
		len_c    = (room > {8'd0, scale_q}) ? scale_q : room[sbtr_pkg::LenBits-1:0];
		row_base = {11'd0, row} * {12'd0, cfg.fb_width};
		idx_sum  = {1'b0, row_base} + {11'd0, col};
		out_free = !out_v_q || out_ready;
	end

	assign sts.out_free   = out_free;
	assign sts.hold_valid = hold_v_q;
	assign sts.iter_last  = next_cell && (cell_q == sbtr_pkg::CELL_LAST);

	// pen column across characters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_q <= '0;
		end else if (cmd.load) begin
			pen_q <= pen_sum[sbtr_pkg::PenBits] ? sbtr_pkg::PEN_MAX
			                                     : pen_sum[sbtr_pkg::PenBits-1:0];
		end
	end

	// walk the glyph cells and their pixel rows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
			dx_q   <= '0;
			r_q    <= '0;
			xoff_q <= '0;
			yoff_q <= '0;
		end else if (cmd.load) begin
			cell_q <= '0;
			dx_q   <= '0;
			r_q    <= '0;
			xoff_q <= '0;
			yoff_q <= '0;
		end else if (cmd.step) begin
			if (next_cell) begin
				r_q    <= '0;
				cell_q <= cell_q + 4'd1;
				if (dx_q == sbtr_pkg::COL_LAST) begin
					dx_q   <= '0;
					xoff_q <= '0;
					yoff_q <= yoff_q + {2'b00, scale_q};
				end else begin
					dx_q   <= dx_q + 2'd1;
					xoff_q <= xoff_q + {1'b0, scale_q};
				end
			end else begin
				r_q <= r_q + 2'd1;
			end
		end
	end

	// character payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q  <= base_c;
			scale_q <= scale_c;
			bits_q  <= glyph_c[sbtr_pkg::GlyphBits-1:0];
		end else if (cmd.step && next_cell) begin
			bits_q  <= bits_q >> 1;
		end
	end

	// hold the newest span until the next one shows whether it is the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
		end else if (cmd.step && emit) begin
			hold_v_q <= 1'b1;
		end else if (cmd.flush) begin
			hold_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && emit) begin
			hold_idx_q <= idx_sum[sbtr_pkg::IndexBits-1:0];
			hold_len_q <= len_c;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if ((cmd.step && emit && hold_v_q) || cmd.flush) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if ((cmd.step && emit && hold_v_q) || cmd.flush) begin
			out_idx_q  <= hold_idx_q;
			out_len_q  <= hold_len_q;
			out_ink_q  <= cfg.ink_color;
			out_last_q <= cmd.flush;
		end
	end

	assign out_valid   = out_v_q;
	assign pixel_index = out_idx_q;
	assign span_length = out_len_q;
	assign ink_value   = out_ink_q;
	assign last_span   = out_last_q;

endmodule
`default_nettype wire

FILE: design/scaled_bitmap_text_rasterizer_unit.sv
// Top level: configuration registers, controller and datapath of the text rasterizer.
// Spans: each span of a character waits in the hold stage until the next one is formed or the
// cell walk ends, then moves to the output register that drives m_tvalid. The walk steps once
// per emitted span, skipped cell or cell cut at the bottom edge, only while the output is free;
// a new character is taken only after the walk and flush end; at most one span leaves per cycle.
// Reset: arst_n clears controller, pen and output register; registers go to 10,10,4,320,240,~0.
`default_nettype none
module scaled_bitmap_text_rasterizer_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// APB configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [sbtr_pkg::AddrBits-1:0] paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	// character input
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [7:0]                    s_tdata,  // [7:0] char_code
	input  wire logic                          s_tuser,  // [0] first_of_string
	// span output
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [63:0]                        m_tdata,  // [21:0] pixel_index,
	                                                     // [24:22] span_length,
	                                                     // [56:25] ink_value, [63:57] zero
	output logic                               m_tlast   // last_span
);

	sbtr_pkg::cfg_t cfg_q;
	sbtr_pkg::cmd_t cmd;
	sbtr_pkg::sts_t sts;
	logic                           wr_en;
	logic [2:0]                     reg_sel;
	logic [sbtr_pkg::IndexBits-1:0] pixel_index;
	logic [sbtr_pkg::LenBits-1:0]   span_length;
	logic [sbtr_pkg::InkBits-1:0]   ink_value;

	assign pready  = 1'b1;
	assign reg_sel = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x    <= 11'd10;
			cfg_q.origin_y    <= 11'd10;
			cfg_q.glyph_scale <= 3'd4;
			cfg_q.fb_width    <= 11'd320;
			cfg_q.fb_height   <= 11'd240;
			cfg_q.ink_color   <= 32'hFFFF_FFFF;
		end else if (wr_en) begin
			unique case (reg_sel)
				sbtr_pkg::REG_ORIGIN_X:    cfg_q.origin_x    <= pwdata[10:0];
				sbtr_pkg::REG_ORIGIN_Y:    cfg_q.origin_y    <= pwdata[10:0];
				sbtr_pkg::REG_GLYPH_SCALE: cfg_q.glyph_scale <= pwdata[2:0];
				sbtr_pkg::REG_FB_WIDTH:    cfg_q.fb_width    <= pwdata[10:0];
				sbtr_pkg::REG_FB_HEIGHT:   cfg_q.fb_height   <= pwdata[10:0];
				sbtr_pkg::REG_INK_COLOR:   cfg_q.ink_color   <= pwdata;
				default: ;
			endcase
		end
	end

	// read back configuration registers
	always_comb begin
		unique case (reg_sel)
			sbtr_pkg::REG_ORIGIN_X:    prdata = {21'd0, cfg_q.origin_x};
			sbtr_pkg::REG_ORIGIN_Y:    prdata = {21'd0, cfg_q.origin_y};
			sbtr_pkg::REG_GLYPH_SCALE: prdata = {29'd0, cfg_q.glyph_scale};
			sbtr_pkg::REG_FB_WIDTH:    prdata = {21'd0, cfg_q.fb_width};
			sbtr_pkg::REG_FB_HEIGHT:   prdata = {21'd0, cfg_q.fb_height};
			sbtr_pkg::REG_INK_COLOR:   prdata = cfg_q.ink_color;
			default:                   prdata = '0;
		endcase
	end

	sbtr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sbtr_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.cmd             (cmd),
		.sts             (sts),
		.char_code       (s_tdata),
		.first_of_string (s_tuser),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.pixel_index     (pixel_index),
		.span_length     (span_length),
		.ink_value       (ink_value),
		.last_span       (m_tlast)
	);

	// pack the span transfer
	assign m_tdata = {7'd0, ink_value, span_length, pixel_index};

endmodule
`default_nettype wire

FILE: design/sbtr_chk.sv
// Port-level checker of the text rasterizer and its bind to the top level.
`default_nettype none
module sbtr_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        pready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [63:0] m_tdata,
	input wire logic        m_tlast
);

	// a stalled span stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("span dropped while stalled");

	// span length always within one cell width
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[24:22] != 3'd0) && (m_tdata[24:22] <= 3'd4))
		else $error("span length out of range");

	// padding bits stay clear
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[63:57] == 7'd0))
		else $error("span padding not zero");

	// configuration port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

	// the last mark is taken together with its data
	a_last_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tlast))
		else $error("last mark changed while stalled");

endmodule

bind scaled_bitmap_text_rasterizer_unit sbtr_chk u_sbtr_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.pready   (pready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
`default_nettype wire

FILE: sim/scaled_bitmap_text_rasterizer_unit_tb.sv
// Self-checking testbench for the scaled bitmap text rasterizer: span prediction and compare.
`default_nettype none
module scaled_bitmap_text_rasterizer_unit_tb;

	localparam int DRAIN_CYCLES   = 80;
	localparam int LONG_HOLD      = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int MAX_REPORTS    = 10;

	// 3x5 font for codes 32..126, bit dy*3+dx is column dx of row dy
	localparam logic [15:0] FONT_BITS [0:94] = '{
		16'h0000,16'h2092,16'h002d,16'h5f7d,16'h279e,16'h52a5,16'h7ad6,16'h0012,
		16'h4494,16'h1491,16'h017a,16'h05d0,16'h1400,16'h01c0,16'h0400,16'h12a4,
		16'h2b6a,16'h749a,16'h752a,16'h38a3,16'h4f4a,16'h38cf,16'h3bce,16'h12a7,
		16'h3aae,16'h49ae,16'h0410,16'h1410,16'h4454,16'h0e38,16'h1511,16'h10e3,
		16'h73ee,16'h5f7a,16'h3beb,16'h624e,16'h3b6b,16'h73cf,16'h13cf,16'h6b4e,
		16'h5bed,16'h7497,16'h2b27,16'h5add,16'h7249,16'h5b7d,16'h5b6b,16'h3b6e,
		16'h12eb,16'h4f6b,16'h5aeb,16'h388e,16'h2497,16'h6b6d,16'h256d,16'h5f6d,
		16'h5aad,16'h24ad,16'h72a7,16'h6496,16'h4889,16'h3493,16'h002a,16'hf000,
		16'h0011,16'h6b98,16'h3b79,16'h7270,16'h7b74,16'h6750,16'h95d6,16'hb9ee,
		16'h5b59,16'h6410,16'hb482,16'h56e8,16'h6492,16'h5be8,16'h5b58,16'h3b70,
		16'h976a,16'hcd6a,16'h1370,16'h38f0,16'h64ba,16'h3b68,16'h2568,16'h5f68,
		16'h54a8,16'hb9ad,16'h73b8,16'h64d6,16'h2492,16'h3593,16'h03e0
	};

	typedef struct packed {
		logic [7:0] code;
		logic       first;
	} char_item_t;

	typedef struct packed {
		logic [sbtr_pkg::IndexBits-1:0] pixel_index;
		logic [sbtr_pkg::LenBits-1:0]   span_length;
		logic [sbtr_pkg::InkBits-1:0]   ink_value;
		logic                           last_span;
	} span_t;

	logic                           clk      = 1'b0;
	logic                           arst_n   = 1'b0;
	logic                           psel     = 1'b0;
	logic                           penable  = 1'b0;
	logic                           pwrite   = 1'b0;
	logic [sbtr_pkg::AddrBits-1:0]  paddr    = '0;
	logic [31:0]                    pwdata   = '0;
	logic [31:0]                    prdata;
	logic                           pready;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [7:0]                     s_tdata  = '0;  // [7:0] char_code
	logic                           s_tuser  = 1'b0;  // [0] first_of_string
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [63:0]                    m_tdata;  // [21:0] pixel_index, [24:22] span_length,
	                                          // [56:25] ink_value, [63:57] zero
	logic                           m_tlast;  // last_span

	// register shadow and pen, as the block should hold them
	logic [sbtr_pkg::CoordBits-1:0] cur_origin_x = 11'd10;
	logic [sbtr_pkg::CoordBits-1:0] cur_origin_y = 11'd10;
	logic [2:0]                     cur_scale    = 3'd4;
	logic [sbtr_pkg::CoordBits-1:0] cur_fb_width = 11'd320;
	logic [sbtr_pkg::CoordBits-1:0] cur_fb_height = 11'd240;
	logic [sbtr_pkg::InkBits-1:0]   cur_ink      = 32'hFFFF_FFFF;
	int unsigned                    pen_col      = 0;

	char_item_t char_pending_q[$];
	span_t      span_expect_q[$];

	int chars_queued   = 0;
	int chars_accepted = 0;
	int spans_expected = 0;
	int spans_seen     = 0;
	int reg_writes     = 0;
	int fault_cnt      = 0;
	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int idle_cycles    = 0;
	int hold_left      = 0;
	logic hold_trigger = 1'b0;
	logic hold_seen    = 1'b0;

	scaled_bitmap_text_rasterizer_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_fault(input string msg);
		fault_cnt++;
		if (fault_cnt <= MAX_REPORTS) begin
			$display("%s", msg);
		end
	endtask

	// work out the spans of one character and advance the pen
	task automatic rasterize_char(input logic [7:0] code, input logic first);
		int unsigned scale, bits, col, len, row, idx;
		span_t       spans[$];
		span_t       sp;
		scale = (cur_scale > sbtr_pkg::MaxScale) ? sbtr_pkg::MaxScale : cur_scale;
		bits  = 0;
		if (first) begin
			pen_col = cur_origin_x;
		end
		if (code > sbtr_pkg::GLYPH_FIRST && code <= sbtr_pkg::GLYPH_LAST) begin
			bits = FONT_BITS[code - sbtr_pkg::GLYPH_FIRST];
		end
		for (int dy = 0; dy < 5 && scale != 0; dy++) begin
			for (int dx = 0; dx < 3; dx++) begin
				if (bits[dy * 3 + dx]) begin
					col = pen_col + dx * scale;
					if (col < cur_fb_width) begin
						len = cur_fb_width - col;
						if (len > scale) begin
							len = scale;
						end
						for (int r = 0; r < scale; r++) begin
							row = cur_origin_y + dy * scale + r;
							if (row >= cur_fb_height) begin
								break;
							end
							idx = row * cur_fb_width + col;
							sp.pixel_index = idx[sbtr_pkg::IndexBits-1:0];
							sp.span_length = len[sbtr_pkg::LenBits-1:0];
							sp.ink_value   = cur_ink;
							sp.last_span   = 1'b0;
							spans.push_back(sp);
						end
					end
				end
			end
		end
		if (spans.size() != 0) begin
			spans[spans.size() - 1].last_span = 1'b1;
		end
		foreach (spans[i]) begin
			span_expect_q.push_back(spans[i]);
		end
		spans_expected += spans.size();
		pen_col += 4 * scale;
		if (pen_col > 4095) begin
			pen_col = 4095;
		end
	endtask

	task automatic queue_char(input logic [7:0] code, input logic first);
		char_item_t it;
		it.code  = code;
		it.first = first;
		char_pending_q.push_back(it);
		chars_queued++;
	endtask

	// mostly strings of printable codes, some blanks and stray items
	task automatic queue_text(input int count);
		int         added, len, sel;
		logic [7:0] code;
		added = 0;
		while (added < count) begin
			if ($urandom_range(99) < 85) begin
				len = $urandom_range(1, 8);
				for (int k = 0; k < len && added < count; k++) begin
					sel = $urandom_range(99);
					if (sel < 80) begin
						code = 8'($urandom_range(33, 126));
					end else if (sel < 88) begin
						code = sbtr_pkg::GLYPH_FIRST;
					end else begin
						code = 8'($urandom_range(255));
					end
					queue_char(code, k == 0);
					added++;
				end
			end else begin
				queue_char(8'($urandom_range(255)), 1'($urandom_range(1)));
				added++;
			end
		end
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			sbtr_pkg::REG_ORIGIN_X:    cur_origin_x  = value[sbtr_pkg::CoordBits-1:0];
			sbtr_pkg::REG_ORIGIN_Y:    cur_origin_y  = value[sbtr_pkg::CoordBits-1:0];
			sbtr_pkg::REG_GLYPH_SCALE: cur_scale     = value[2:0];
			sbtr_pkg::REG_FB_WIDTH:    cur_fb_width  = value[sbtr_pkg::CoordBits-1:0];
			sbtr_pkg::REG_FB_HEIGHT:   cur_fb_height = value[sbtr_pkg::CoordBits-1:0];
			sbtr_pkg::REG_INK_COLOR:   cur_ink       = value;
			default: ;
		endcase
		reg_writes++;
	endtask

	// hold until every character is in and every span is out, then let the
	// block finish any character that emits nothing
	task automatic wait_drained();
		while (chars_accepted != chars_queued || span_expect_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_setting(input int ox, input int oy, input int sc, input int w,
			input int h, input logic [31:0] ink);
		wait_drained();
		reg_write(sbtr_pkg::REG_ORIGIN_X, ox);
		reg_write(sbtr_pkg::REG_ORIGIN_Y, oy);
		reg_write(sbtr_pkg::REG_GLYPH_SCALE, sc);
		reg_write(sbtr_pkg::REG_FB_WIDTH, w);
		reg_write(sbtr_pkg::REG_FB_HEIGHT, h);
		reg_write(sbtr_pkg::REG_INK_COLOR, ink);
	endtask

	// drive characters; hold each transfer until it is taken
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				rasterize_char(s_tdata, s_tuser);
				chars_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (char_pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= char_pending_q[0].code;
					s_tuser  <= char_pending_q[0].first;
					void'(char_pending_q.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// check spans and throttle the output side
	always @(posedge clk) begin
		span_t exp_span;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				spans_seen++;
				if (span_expect_q.size() == 0) begin
					report_fault($sformatf("unexpected span: index %0d len %0d ink %h last %b",
						m_tdata[21:0], m_tdata[24:22], m_tdata[56:25], m_tlast));
				end else begin
					exp_span = span_expect_q.pop_front();
					if (m_tdata[21:0] !== exp_span.pixel_index ||
							m_tdata[24:22] !== exp_span.span_length ||
							m_tdata[56:25] !== exp_span.ink_value ||
							m_tlast !== exp_span.last_span) begin
						report_fault($sformatf({"span mismatch: expected index %0d len %0d ink %h ",
							"last %b, got index %0d len %0d ink %h last %b"},
							exp_span.pixel_index, exp_span.span_length, exp_span.ink_value,
							exp_span.last_span, m_tdata[21:0], m_tdata[24:22],
							m_tdata[56:25], m_tlast));
					end
				end
			end
			if (hold_trigger != hold_seen) begin
				hold_seen = hold_trigger;
				hold_left = LONG_HOLD;
				m_tready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer in %0d cycles, %0d spans outstanding",
					idle_cycles, span_expect_q.size());
				$display("scaled_bitmap_text_rasterizer_unit_tb: errors");
				$finish;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset setting: pen from zero, all blank kinds, dense glyphs, string start
		queue_char(8'd33, 1'b0);
		queue_char(8'd35, 1'b0);
		queue_char(sbtr_pkg::GLYPH_LAST, 1'b0);
		queue_char(sbtr_pkg::GLYPH_FIRST, 1'b0);
		queue_char(8'd0, 1'b0);
		queue_char(8'd127, 1'b0);
		queue_char(8'd128, 1'b0);
		queue_char(8'd255, 1'b0);
		queue_char(8'd64, 1'b1);
		queue_char(8'd48, 1'b0);

		// right and bottom clipping, scale above the maximum
		load_setting(300, 225, 7, 310, 236, 32'h0000_0000);
		queue_char(8'd35, 1'b1);
		queue_char(8'd87, 1'b0);
		queue_char(8'd33, 1'b0);

		// scale zero: nothing drawn, pen stays
		load_setting(0, 0, 0, 2047, 2047, 32'hFFFF_FFFF);
		queue_char(8'd35, 1'b1);
		queue_char(8'd65, 1'b0);

		// empty and single-pixel framebuffers
		load_setting(0, 0, 1, 0, 5, 32'h1234_5678);
		queue_char(8'd35, 1'b1);
		load_setting(0, 0, 1, 5, 0, 32'h1234_5678);
		queue_char(8'd35, 1'b1);
		load_setting(0, 0, 2, 1, 1, 32'h8000_0001);
		queue_char(8'd35, 1'b1);

		// far corner of the largest framebuffer
		load_setting(2044, 2040, 1, 2047, 2047, 32'h5A5A_A5A5);
		queue_char(8'd35, 1'b1);
		queue_char(sbtr_pkg::GLYPH_LAST, 1'b0);
		queue_char(8'd33, 1'b0);

		// random text, back to back
		load_setting($urandom_range(0, 200), $urandom_range(0, 200), $urandom_range(1, 4),
			$urandom_range(240, 2047), $urandom_range(160, 2047), $urandom);
		queue_text(30);

		// small framebuffers, any scale code, sender gaps
		load_setting($urandom_range(0, 60), $urandom_range(0, 40), $urandom_range(0, 7),
			$urandom_range(1, 120), $urandom_range(1, 60), $urandom);
		src_idle_pct = 62;
		queue_text(30);

		// full scale with output stalls, opening with a long hold-off
		load_setting(10, 10, 4, 320, 240, $urandom);
		src_idle_pct   = 0;
		sink_stall_pct = 62;
		hold_trigger   = ~hold_trigger;
		queue_text(30);

		// both sides idle now and then
		load_setting($urandom_range(0, 500), $urandom_range(0, 300), $urandom_range(1, 4),
			$urandom_range(1, 2047), $urandom_range(1, 2047), $urandom);
		src_idle_pct   = 21;
		sink_stall_pct = 21;
		queue_text(30);

		// one long string near the corner, run the pen into saturation
		load_setting(2000, 2036, 4, 2047, 2047, $urandom);
		queue_char(8'($urandom_range(33, 126)), 1'b1);
		repeat (134) queue_char(8'($urandom_range(33, 126)), 1'b0);

		wait_drained();
		if (span_expect_q.size() != 0) begin
			report_fault($sformatf("%0d spans never arrived", span_expect_q.size()));
		end
		$display("run: %0d characters, %0d of %0d spans checked, %0d register writes",
			chars_accepted, spans_seen, spans_expected, reg_writes);
		$display("run: clipping, blank codes, scale 0..7, idle and stall mixes, pen saturation");
		if (fault_cnt == 0) begin
			$display("scaled_bitmap_text_rasterizer_unit_tb: clean");
		end else begin
			$display("%0d mismatches in total", fault_cnt);
			$display("scaled_bitmap_text_rasterizer_unit_tb: errors");
		end
		$finish;
	end

endmodule
`default_nettype wire
